>>> rtl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned Rounds = 10;
  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [RegIdxW-1:0] RegKeyLow = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    block_t state;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01;
      4'd1: v = 8'h02;
      4'd2: v = 8'h04;
      4'd3: v = 8'h08;
      4'd4: v = 8'h10;
      4'd5: v = 8'h20;
      4'd6: v = 8'h40;
      4'd7: v = 8'h80;
      4'd8: v = 8'h1b;
      4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // byte i of the block sits in bits 127-8i downto 120-8i
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> rtl/aes_key_step.sv
module aes_key_step import aes_pkg::*; #(
  parameter logic [3:0] RoundIdx = 4'd0
) (
  input  block_t rk_in,
  output block_t rk_out
);

  logic [7:0] t [4];
  logic [7:0] o [16];

  always_comb begin
    t[0] = sbox(get_byte(rk_in, 13)) ^ rcon(RoundIdx);
    t[1] = sbox(get_byte(rk_in, 14));
    t[2] = sbox(get_byte(rk_in, 15));
    t[3] = sbox(get_byte(rk_in, 12));
    for (int i = 0; i < 4; i++) o[i] = get_byte(rk_in, i) ^ t[i];
    for (int i = 4; i < 16; i++) o[i] = get_byte(rk_in, i) ^ o[i-4];
    for (int i = 0; i < 16; i++) rk_out[BlockW-1-8*i -: 8] = o[i];
  end

endmodule

>>> rtl/aes_round.sv
module aes_round import aes_pkg::*; #(
  parameter bit FinalRound = 1'b0
) (
  input  block_t state_in,
  input  block_t rk,
  output block_t state_out
);

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] all;

  always_comb begin
    all = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = sbox(get_byte(state_in, 4*((c+r)%4)+r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++) begin
        if (FinalRound) begin
          m[4*c+r] = t[4*c+r];
        end else begin
          m[4*c+r] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
        end
      end
    end
    for (int i = 0; i < 16; i++) state_out[BlockW-1-8*i -: 8] = m[i] ^ get_byte(rk, i);
  end

endmodule

>>> rtl/aes128_ecb_block_encrypt.sv
// AES-128 ECB encryption, one block per clock unless the sink stalls. Each of
// the ten rounds, with its round-key expansion, owns one pipeline register,
// after one register for the initial key add. tready drops only while every
// stage holds a word and the sink is not ready; the key registers are written
// through the write port and the key travels down the pipe with each word, so
// a key write is seen by words accepted after it.
module aes128_ecb_block_encrypt import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [RegIdxW-1:0] wr_index,
  input  logic [63:0]  wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // plain_low, plain_high
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // cipher_low, cipher_high
  output logic         m_axis_tlast
);

  localparam int unsigned Stages = Rounds + 1;

  logic [63:0] key_high;
  logic [63:0] key_low;
  stage_t      stg [Stages];
  block_t      rkey [Stages];
  stage_t      stg_next [Stages];
  block_t      rkey_next [Stages];
  logic        adv [Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        RegKeyHigh: key_high <= wr_data;
        RegKeyLow:  key_low  <= wr_data;
        default: ;
      endcase
    end
  end

  // a stage moves when empty or when its successor moves
  always_comb begin
    adv[Stages-1] = !stg[Stages-1].valid || m_axis_tready;
    for (int i = Stages - 2; i >= 0; i--) adv[i] = !stg[i].valid || adv[i+1];
  end

  assign s_axis_tready = adv[0];

  assign stg_next[0].valid = s_axis_tvalid;
  assign stg_next[0].last  = s_axis_tlast;
  assign stg_next[0].state = {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {key_high, key_low};
  assign rkey_next[0]      = {key_high, key_low};

  for (genvar g = 1; g < Stages; g++) begin : g_round
    aes_key_step #(.RoundIdx(4'(g - 1))) u_key (
      .rk_in (rkey[g-1]),
      .rk_out(rkey_next[g])
    );
    aes_round #(.FinalRound(g == Stages - 1)) u_round (
      .state_in (stg[g-1].state),
      .rk       (rkey_next[g]),
      .state_out(stg_next[g].state)
    );
    assign stg_next[g].valid = stg[g-1].valid;
    assign stg_next[g].last  = stg[g-1].last;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Stages; i++) begin
      if (rst) begin
        stg[i].valid <= 1'b0;
      end else if (adv[i]) begin
        stg[i].valid <= stg_next[i].valid;
      end
      if (adv[i]) begin
        stg[i].last  <= stg_next[i].last;
        stg[i].state <= stg_next[i].state;
        rkey[i]      <= rkey_next[i];
      end
    end
  end

  assign m_axis_tvalid = stg[Stages-1].valid;
  assign m_axis_tdata  = {stg[Stages-1].state[63:0], stg[Stages-1].state[127:64]};
  assign m_axis_tlast  = stg[Stages-1].last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    stg[Stages-1].valid && !m_axis_tready |=> stg[Stages-1].valid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !stg[0].valid |-> s_axis_tready)
    else $error("empty entry stage refused a word");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    stg[0].valid && adv[1] |=> stg[1].valid)
    else $error("word lost between stages");

endmodule

>>> test/aes128_ecb_block_encrypt_chk.sv
`timescale 1ns / 100ps

module aes128_ecb_block_encrypt_chk import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [RegIdxW-1:0] wr_index,
  input  logic [63:0]  wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           errors,
  output int           pending
);

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_word_t;

  logic [7:0]   sub_tab [256];
  logic [63:0]  key_hi, key_lo;
  cipher_word_t cipher_q [$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  // sbox from the field inverse and the affine map
  initial begin
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = b;
    end
  end

  function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] rk [16];
    logic [7:0] t [16];
    logic [7:0] rc, a0, a1, a2, a3, all;
    logic [127:0] r;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int rnd = 0; rnd < 10; rnd++) begin
      t[0] = sub_tab[rk[13]] ^ rc;
      t[1] = sub_tab[rk[14]];
      t[2] = sub_tab[rk[15]];
      t[3] = sub_tab[rk[12]];
      for (int i = 0; i < 4; i++) rk[i] ^= t[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rc = gf_dbl(rc);
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++)
          t[4*c+w] = sub_tab[s[4*((c+w)%4)+w]];
      if (rnd != 9) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    cipher_word_t e;
    logic [127:0] c;
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
      errors = 0;
    end else begin
      if (wr_en) begin
        if (wr_index == RegKeyHigh) key_hi <= wr_data;
        else if (wr_index == RegKeyLow) key_lo <= wr_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c = encrypt({key_hi, key_lo}, {s_axis_tdata[63:0], s_axis_tdata[127:64]});
        e.hi = c[127:64];
        e.lo = c[63:0];
        e.last = s_axis_tlast;
        cipher_q.push_back(e);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected word %h last %b", $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          e = cipher_q.pop_front();
          if (m_axis_tdata[63:0] !== e.hi) begin
            $display("%0t: cipher_high exp %h got %h", $time, e.hi, m_axis_tdata[63:0]);
            errors++;
          end
          if (m_axis_tdata[127:64] !== e.lo) begin
            $display("%0t: cipher_low exp %h got %h", $time, e.lo, m_axis_tdata[127:64]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> test/aes128_ecb_block_encrypt_tb.sv
`timescale 1ns / 100ps

module aes128_ecb_block_encrypt_tb;
  import aes_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [RegIdxW-1:0] wr_index = RegKeyHigh;
  logic [63:0]        wr_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [127:0]       s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [127:0]       m_axis_tdata;
  logic               m_axis_tlast;
  int                 errors, pending;
  bit                 steady = 1'b0;
  int                 hold_req_n = 0;
  int                 sent = 0;
  int                 keys_used = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aes128_ecb_block_encrypt uut (.*);

  aes128_ecb_block_encrypt_chk chk (.*);

  // sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    static int hold_left = 0;
    static int hold_done_n = 0;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_done_n != hold_req_n) begin
      hold_done_n = hold_req_n;
      hold_left = 80;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end
  end

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= RegKeyHigh;
    wr_data <= hi;
    @(posedge clk);
    wr_index <= RegKeyLow;
    wr_data <= lo;
    @(posedge clk);
    wr_en <= 1'b0;
    keys_used++;
  endtask

  task automatic send(input logic [63:0] hi, input logic [63:0] lo, input logic last);
    if (!steady && $urandom_range(99) < 24) begin
      @(posedge clk);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(posedge clk);
    end
    @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lo, hi};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_run(input int n);
    repeat (n) send(rand64(), rand64(), $urandom_range(1));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset key of all zeros
    send('0, '0, 1'b0);
    send('1, '1, 1'b1);
    send(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    send(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
    drain();

    // standard test vector and neighbors
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
    send('0, '0, 1'b0);
    send('1, '1, 1'b1);
    for (int i = 0; i < 8; i++) send(64'h1 << (8 * i + i), 64'h1 << (63 - 8 * i), i[0]);
    drain();

    set_key('1, '1);
    send('0, '0, 1'b1);
    send('1, '1, 1'b0);
    send(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
    drain();

    set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
    drain();

    // random phases, each under a fresh key
    for (int ph = 0; ph < 6; ph++) begin
      set_key(rand64(), rand64());
      if (ph == 2) begin
        steady = 1'b1;
        random_run(200);
        steady = 1'b0;
      end else if (ph == 3) begin
        random_run(100);
        hold_req_n++;
        steady = 1'b1;
        random_run(60);
        steady = 1'b0;
        random_run(100);
      end else begin
        random_run(250);
      end
      drain();
    end

    set_key('0, '0);
    random_run(200);
    drain();

    $display("encrypted %0d blocks under %0d keys, with random stalls on both sides", sent,
             keys_used);
    $display("including a long sink hold-off and an unstalled stretch");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
